[design/nq_pkg.sv]
`timescale 1ns / 1ps
package nq_pkg;

	// Largest board the cell chain can hold; one cell per column.
	localparam int MAX_SIZE = 16;
	localparam int ROW_W = $clog2(MAX_SIZE);
	// Board size field on the input stream.
	localparam int SIZE_W = 5;
	// Column and row fields on the output stream.
	localparam int FIELD_W = 4;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_PAD_W = OUT_TDATA_W - 2 * FIELD_W - 1;
	localparam int IN_PAD_W = IN_TDATA_W - SIZE_W;

	typedef logic [MAX_SIZE-1:0] nq_mask_t;

	// Command from the sequencer to one column cell.
	typedef struct packed {
		logic active;
		logic resume;
	} nq_cmd_t;

	// Outcome of one search step in the active cell.
	typedef struct packed {
		logic placed;
		logic exhausted;
	} nq_status_t;

endpackage

[design/nq_cell.sv]
`timescale 1ns / 1ps
// One board column. It keeps its queen and the occupancy masks it hands on to
// the next column, with the diagonal masks already shifted for that column.
module nq_cell import nq_pkg::*; (
	input  logic              clk,
	input  nq_cmd_t           cmd,
	input  nq_mask_t          size_mask,
	input  nq_mask_t          row_in,
	input  nq_mask_t          dn_in,
	input  nq_mask_t          up_in,
	output nq_mask_t          row_out,
	output nq_mask_t          dn_out,
	output nq_mask_t          up_out,
	output logic [ROW_W-1:0]  queen_row,
	output nq_status_t        status
);

	logic [ROW_W-1:0] queen_q;
	nq_mask_t         row_q;
	nq_mask_t         dn_q;
	nq_mask_t         up_q;
	nq_mask_t         above;
	nq_mask_t         cand;
	nq_mask_t         pick_oh;
	logic [ROW_W-1:0] pick_idx;

	// When resuming after a backtrack, only rows past the old queen are tried.
	always_comb begin
		for (int i = 0; i < MAX_SIZE; i++) begin
			above[i] = (i > int'(queen_q));
		end
	end

	assign cand    = ~(row_in | dn_in | up_in) & size_mask & (cmd.resume ? above : '1);
	assign pick_oh = cand & (~cand + nq_mask_t'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = MAX_SIZE - 1; i >= 0; i--) begin
			if (cand[i]) begin
				pick_idx = ROW_W'(i);
			end
		end
	end

	assign status.placed    = cmd.active && (|cand);
	assign status.exhausted = cmd.active && !(|cand);

	always_ff @(posedge clk) begin
		if (status.placed) begin
			queen_q <= pick_idx;
			row_q   <= row_in | pick_oh;
			dn_q    <= (dn_in | pick_oh) << 1;
			up_q    <= (up_in | pick_oh) >> 1;
		end
	end

	assign row_out   = row_q;
	assign dn_out    = dn_q;
	assign up_out    = up_q;
	assign queen_row = queen_q;

endmodule

[design/nq_ctrl.sv]
`timescale 1ns / 1ps
// Search sequencer and output register.
module nq_ctrl import nq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_TDATA_W-1:0]   s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,
	output logic                    m_tlast,
	output nq_cmd_t                 cmds [MAX_SIZE],
	output nq_mask_t                size_mask,
	input  nq_status_t              status [MAX_SIZE],
	input  logic [ROW_W-1:0]        queen_rows [MAX_SIZE]
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [SIZE_W-1:0]  n_q;
	logic [ROW_W-1:0]   col_q;
	logic               resume_q;
	logic               found_q;
	logic [ROW_W-1:0]   emit_q;
	logic               m_tvalid_q;
	logic [FIELD_W-1:0] col_out_q;
	logic [FIELD_W-1:0] row_out_q;
	logic               found_out_q;
	logic               last_q;

	logic [SIZE_W-1:0]  size_in;
	logic [SIZE_W-1:0]  n_sat;
	nq_status_t         cur;
	logic               last_col;
	logic               last_beat;
	logic               out_free;
	logic               load_out;

	assign size_in   = s_tdata[SIZE_W-1:0];
	assign n_sat     = (size_in > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_in;
	assign s_tready  = (state_q == ST_IDLE);
	assign cur       = status[col_q];
	assign last_col  = ((SIZE_W'(col_q) + SIZE_W'(1)) == n_q);
	assign last_beat = !found_q || ((SIZE_W'(emit_q) + SIZE_W'(1)) == n_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign load_out  = (state_q == ST_EMIT) && out_free;

	always_comb begin
		for (int i = 0; i < MAX_SIZE; i++) begin
			size_mask[i]     = (i < int'(n_q));
			cmds[i].active   = (state_q == ST_SEARCH) && (col_q == ROW_W'(i));
			cmds[i].resume   = resume_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			col_q       <= '0;
			resume_q    <= 1'b0;
			found_q     <= 1'b0;
			emit_q      <= '0;
			m_tvalid_q  <= 1'b0;
			col_out_q   <= '0;
			row_out_q   <= '0;
			found_out_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						n_q      <= n_sat;
						col_q    <= '0;
						resume_q <= 1'b0;
						emit_q   <= '0;
						found_q  <= 1'b0;
						state_q  <= (n_sat == '0) ? ST_EMIT : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (cur.placed) begin
						if (last_col) begin
							found_q <= 1'b1;
							emit_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							col_q    <= col_q + ROW_W'(1);
							resume_q <= 1'b0;
						end
					end else if (col_q == '0) begin
						found_q <= 1'b0;
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						col_q    <= col_q - ROW_W'(1);
						resume_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						col_out_q   <= found_q ? FIELD_W'(emit_q) : '0;
						row_out_q   <= found_q ? FIELD_W'(queen_rows[emit_q]) : '0;
						found_out_q <= found_q;
						last_q      <= last_beat;
						emit_q      <= emit_q + ROW_W'(1);
						if (last_beat) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, found_out_q, row_out_q, col_out_q};
	assign m_tlast  = last_q;

endmodule

[design/n_queens_first_solution.sv]
// First solution of the N-queens puzzle by depth-first backtracking.
// Each input beat on the slave stream carries a board size (1 to 16; larger
// sizes saturate to 16, size 0 counts as unsolvable). The block places one
// queen per column, trying rows in ascending order, and answers on the master
// stream with one beat per column giving that column's queen row, found set,
// and tlast on the final column. When no solution exists (sizes 2 and 3) it
// sends a single beat with column and row zero, found clear and tlast set.
// The search runs in a chain of column cells. Each cell keeps its queen and
// the row and diagonal masks it passes to the next cell; the active cell
// decides to place or give up combinationally, so the search takes one
// placement or backtrack step per cycle, then sends one output beat per cycle
// while the receiver accepts. One board is handled at a time: tready is high
// only while the sequencer is idle. A finished beat waits in the output
// register while the receiver stalls, and the next board may be taken as soon
// as the last beat is loaded there. Reset returns the sequencer to idle and
// drops tvalid; the cell masks need no clearing, since every search rebuilds
// them from column zero.
`timescale 1ns / 1ps
module n_queens_first_solution import nq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_TDATA_W-1:0]   s_tdata,   // [4:0] board_size, [7:5] zero
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,   // [3:0] column_index, [7:4] queen_row,
	                                           // [8] found, [15:9] zero
	output logic                    m_tlast
);

	nq_cmd_t          cmds       [MAX_SIZE];
	nq_status_t       status     [MAX_SIZE];
	logic [ROW_W-1:0] queen_rows [MAX_SIZE];
	nq_mask_t         size_mask;
	// Masks between neighboring cells; entry zero feeds the first column.
	nq_mask_t         row_c      [MAX_SIZE+1];
	nq_mask_t         dn_c       [MAX_SIZE+1];
	nq_mask_t         up_c       [MAX_SIZE+1];
	logic [MAX_SIZE-1:0] placed_vec;
	logic [MAX_SIZE-1:0] exhausted_vec;

	assign row_c[0] = '0;
	assign dn_c[0]  = '0;
	assign up_c[0]  = '0;

	for (genvar g = 0; g < MAX_SIZE; g++) begin : g_col
		nq_cell u_cell (
			.clk       (clk),
			.cmd       (cmds[g]),
			.size_mask (size_mask),
			.row_in    (row_c[g]),
			.dn_in     (dn_c[g]),
			.up_in     (up_c[g]),
			.row_out   (row_c[g+1]),
			.dn_out    (dn_c[g+1]),
			.up_out    (up_c[g+1]),
			.queen_row (queen_rows[g]),
			.status    (status[g])
		);
		assign placed_vec[g]    = status[g].placed;
		assign exhausted_vec[g] = status[g].exhausted;
	end

	nq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cmds       (cmds),
		.size_mask  (size_mask),
		.status     (status),
		.queen_rows (queen_rows)
	);

	// Only the active column may act, and it either places or gives up.
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({placed_vec, exhausted_vec}))
		else $error("more than one cell acted in a search step");

	// An unsolvable board is answered by one beat with zero column and row.
	a_fail_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2*FIELD_W]) |-> (m_tlast && (m_tdata[2*FIELD_W-1:0] == '0)))
		else $error("no-solution beat is malformed");

	// A beat that waits for the receiver keeps its last mark.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		($past(m_tvalid) && !$past(m_tready)) |-> (m_tvalid && $stable(m_tlast)))
		else $error("stalled beat changed");

endmodule
